@@ rtl/core/ehtq_pkg.sv @@
// shared types and constants of the energy histogram block
`timescale 1ns / 1ps
`default_nettype none
package ehtq_pkg;

    localparam int DEF_NUM_BINS    = 8192;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int ENERGY_W        = 24;
    localparam int BIN_W           = 13;
    localparam int OUT_W           = 32;
    localparam int ADDR_MAX_W      = 16;
    localparam int CFG_W           = 24;

    localparam logic [15:0] RST_BIN_WIDTH   = 16'd256;
    localparam logic [23:0] RST_MIN_ENERGY  = 24'd128;
    localparam logic [13:0] RST_ACTIVE_BINS = 14'd5000;
    localparam logic [9:0]  RST_THRESHOLD   = 10'd2;

    typedef enum logic [1:0] {
        REQ_INS_DET = 2'd0,
        REQ_INS_EMI = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_BIN_WIDTH   = 2'd0,
        CFG_MIN_ENERGY  = 2'd1,
        CFG_ACTIVE_BINS = 2'd2,
        CFG_THRESHOLD   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_EMIT
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_DATA,
        B_DONE
    } back_state_t;

    // classified request handed from front to back
    typedef struct packed {
        req_t                  req;
        logic                  oor;
        logic [BIN_W-1:0]      bin_used;
        logic [ADDR_MAX_W-1:0] addr;
    } mid_t;

    typedef struct packed {
        logic             out_of_range;
        logic [BIN_W-1:0] bin_used;
        logic [OUT_W-1:0] detected_count;
        logic [OUT_W-1:0] emitted_count;
        logic             passes_threshold;
        logic [OUT_W-1:0] bin_centre;
    } res_t;

endpackage
`default_nettype wire

@@ rtl/core/ehtq_fifo.sv @@
// small register queue
`timescale 1ns / 1ps
`default_nettype none
module ehtq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_rd)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ehtq_front.sv @@
// front end: accepts requests, divides energy into a bin, classifies
`timescale 1ns / 1ps
`default_nettype none
module ehtq_front
    import ehtq_pkg::*;
#(
    parameter int NUM_BINS = DEF_NUM_BINS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          req_type,
    input  wire logic [ENERGY_W-1:0] energy,
    input  wire logic [BIN_W-1:0]    bin_index,
    input  wire logic                clearing,
    input  wire logic [15:0]         bin_width,
    input  wire logic [13:0]         active_bins,
    output logic                     mid_push,
    output mid_t                     mid_data,
    input  wire logic                mid_full
);
    localparam int LW = 17;

    front_state_t         state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [ENERGY_W-1:0]  quo_reg, quo_next;
    logic [15:0]          rem_reg, rem_next;
    logic [4:0]           step_reg, step_next;
    logic [BIN_W-1:0]     qbin_reg, qbin_next;
    logic [15:0]          w_eff;
    logic [16:0]          trial;
    logic [LW-1:0]        limit;
    logic [ENERGY_W-1:0]  value;
    logic                 is_ins;

    assign w_eff  = (bin_width == '0) ? 16'd1 : bin_width;
    assign limit  = (LW'(active_bins) < LW'(NUM_BINS)) ? LW'(active_bins) : LW'(NUM_BINS);
    assign trial  = {rem_reg, quo_reg[ENERGY_W-1]};
    assign is_ins = (req_reg == REQ_INS_DET) || (req_reg == REQ_INS_EMI);
    assign value  = is_ins ? quo_reg : ENERGY_W'(qbin_reg);
    assign full   = (state_reg != F_IDLE) || clearing;

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        qbin_next  = qbin_reg;
        mid_push   = 1'b0;
        mid_data.req      = req_reg;
        mid_data.oor      = 1'b0;
        mid_data.bin_used = '0;
        mid_data.addr     = ADDR_MAX_W'(value[ADDR_MAX_W-1:0]);
        unique case (state_reg)
            F_IDLE:
            begin
                if (push && !clearing)
                begin
                    req_next  = req_t'(req_type);
                    quo_next  = energy;
                    rem_next  = '0;
                    step_next = '0;
                    qbin_next = bin_index;
                    if (req_type == REQ_INS_DET || req_type == REQ_INS_EMI)
                    begin
                        state_next = F_DIV;
                    end
                    else
                    begin
                        state_next = F_EMIT;
                    end
                end
            end
            F_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (trial >= {1'b0, w_eff})
                begin
                    rem_next = 16'(trial - {1'b0, w_eff});
                    quo_next = {quo_reg[ENERGY_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[15:0];
                    quo_next = {quo_reg[ENERGY_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 5'(ENERGY_W - 1))
                begin
                    state_next = F_EMIT;
                end
            end
            F_EMIT:
            begin
                if (req_reg != REQ_CLEAR)
                begin
                    mid_data.oor      = (value >= ENERGY_W'(limit));
                    mid_data.bin_used = (value > ENERGY_W'(8191)) ? '1 : value[BIN_W-1:0];
                end
                if (!mid_full)
                begin
                    mid_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        qbin_reg <= qbin_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/ehtq_back.sv @@
// back end: histogram memories, maximum tracking, queries and clearing
`timescale 1ns / 1ps
`default_nettype none
module ehtq_back
    import ehtq_pkg::*;
#(
    parameter int NUM_BINS    = DEF_NUM_BINS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire mid_t         head,
    input  wire logic         mid_empty,
    output logic              mid_pop,
    input  wire logic [15:0]  bin_width,
    input  wire logic [23:0]  min_energy,
    input  wire logic [9:0]   threshold,
    output logic              clearing,
    output logic              res_push,
    output res_t              res,
    input  wire logic         out_full
);
    localparam int AW = $clog2(NUM_BINS);
    localparam int W  = COUNT_WIDTH;
    localparam int PW = COUNT_WIDTH + 11;

    logic [W-1:0] det_mem [NUM_BINS];
    logic [W-1:0] emi_mem [NUM_BINS];

    back_state_t  state_reg, state_next;
    mid_t         cur_reg, cur_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [W-1:0] max_reg, max_next;
    logic [PW-1:0] pdet_reg, pdet_next, pthr_reg, pthr_next;
    logic [W-1:0] emi_reg, emi_next, det_reg, det_next;
    logic [OUT_W-1:0] centre_reg, centre_next;
    logic [W-1:0] det_rd, emi_rd, sel, inc;
    logic         det_we, emi_we, max_clr;
    logic [AW-1:0] wr_addr;
    logic [W-1:0] wr_data;
    logic [15:0]  w_eff;
    logic [32:0]  centre_full;
    logic [63:0]  det_x, emi_x;

    assign w_eff    = (bin_width == '0) ? 16'd1 : bin_width;
    assign clearing = (state_reg == B_CLEAR);
    assign sel      = (cur_reg.req == REQ_INS_DET) ? det_rd : emi_rd;
    assign inc      = (sel == '1) ? sel : sel + 1'b1;

    always_comb
    begin
        centre_full = 33'(cur_reg.bin_used) * 33'(w_eff) + 33'(w_eff[15:1])
                      + 33'(min_energy);
        det_x = '0;
        emi_x = '0;
        det_x[W-1:0] = det_reg;
        emi_x[W-1:0] = emi_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        sweep_next  = sweep_reg;
        max_next    = max_reg;
        pdet_next   = pdet_reg;
        pthr_next   = pthr_reg;
        det_next    = det_reg;
        emi_next    = emi_reg;
        centre_next = centre_reg;
        mid_pop     = 1'b0;
        res_push    = 1'b0;
        res         = '0;
        det_we      = 1'b0;
        emi_we      = 1'b0;
        max_clr     = 1'b0;
        wr_addr     = cur_reg.addr[AW-1:0];
        wr_data     = inc;
        unique case (state_reg)
            B_CLEAR:
            begin
                det_we     = 1'b1;
                emi_we     = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AW'(NUM_BINS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                // out queue has room here, so the later push always lands
                if (!mid_empty && !out_full)
                begin
                    mid_pop  = 1'b1;
                    cur_next = head;
                    if (head.req == REQ_CLEAR)
                    begin
                        res_push   = 1'b1;
                        max_clr    = 1'b1;
                        max_next   = '0;
                        sweep_next = '0;
                        state_next = B_CLEAR;
                    end
                    else if (head.oor)
                    begin
                        res_push         = 1'b1;
                        res.out_of_range = 1'b1;
                        res.bin_used     = head.bin_used;
                    end
                    else
                    begin
                        state_next = B_DATA;
                    end
                end
            end
            B_DATA:
            begin
                if (cur_reg.req == REQ_QUERY)
                begin
                    det_next    = det_rd;
                    emi_next    = emi_rd;
                    // det >= floor(max*t/1000) rewritten without a divide
                    pdet_next   = PW'(det_rd) * PW'(1000) + PW'(999);
                    pthr_next   = PW'(max_reg) * PW'(threshold);
                    centre_next = centre_full[32] ? '1 : centre_full[31:0];
                    state_next  = B_DONE;
                end
                else
                begin
                    det_we = (cur_reg.req == REQ_INS_DET);
                    emi_we = (cur_reg.req == REQ_INS_EMI);
                    if (cur_reg.req == REQ_INS_DET && inc > max_reg)
                    begin
                        max_next = inc;
                    end
                    res_push     = 1'b1;
                    res.bin_used = cur_reg.bin_used;
                    state_next   = B_IDLE;
                end
            end
            B_DONE:
            begin
                res_push             = 1'b1;
                res.bin_used         = cur_reg.bin_used;
                res.detected_count   = det_x[OUT_W-1:0];
                res.emitted_count    = emi_x[OUT_W-1:0];
                res.passes_threshold = (pdet_reg >= pthr_reg) && (emi_reg != '0);
                res.bin_centre       = centre_reg;
                state_next           = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            sweep_reg <= '0;
            max_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            max_reg   <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        pdet_reg   <= pdet_next;
        pthr_reg   <= pthr_next;
        det_reg    <= det_next;
        emi_reg    <= emi_next;
        centre_reg <= centre_next;
    end

    always_ff @(posedge clk)
    begin
        if (det_we)
        begin
            det_mem[wr_addr] <= wr_data;
        end
        det_rd <= det_mem[head.addr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (emi_we)
        begin
            emi_mem[wr_addr] <= wr_data;
        end
        emi_rd <= emi_mem[head.addr[AW-1:0]];
    end

    a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !res_push)
        else $error("result pushed during clearing sweep");

    a_max_only_drops_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (max_next < max_reg) |-> max_clr)
        else $error("maximum dropped without a clear");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !out_full)
        else $error("result pushed into full output queue");

    a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DATA || state_reg == B_DONE) |-> !mid_pop)
        else $error("request popped while another is in flight");

endmodule
`default_nettype wire

@@ rtl/core/energy_histogram_threshold_query.sv @@
// energy histogram with threshold query
// requests enter through push/full and results leave through empty/pop, both
// queue-style; each request gives exactly one result, in order
// req_type 0/1 increments the detected/emitted bin floor(energy/bin_width),
// 2 reads both counts of bin_index with centre energy and pass flag, 3 clears
// an insert passes the bit-serial divider of the front end, is handed over,
// then is popped for a read-modify-write of the histogram memory in the back
// end; a query is handed over, then goes through memory read, product stage
// and result; an out-of-range request gives its result as it is popped
// the front end accepts a new request as soon as the previous one has moved
// into the two-entry queue ahead of the back end
// after reset, and after each clear, the back end zeroes both memories at
// one bin per cycle; full stays high during that sweep,
// configuration writes are still taken
// when pop is held low, results collect in a two-entry output queue and then
// the back end and, behind it, the front end stall
`timescale 1ns / 1ps
`default_nettype none
module energy_histogram_threshold_query
    import ehtq_pkg::*;
#(
    parameter int NUM_BINS    = DEF_NUM_BINS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          req_type,
    input  wire logic [ENERGY_W-1:0] energy,
    input  wire logic [BIN_W-1:0]    bin_index,
    output logic                     empty,
    input  wire logic                pop,
    output logic                     out_of_range,
    output logic [BIN_W-1:0]         bin_used,
    output logic [OUT_W-1:0]         detected_count,
    output logic [OUT_W-1:0]         emitted_count,
    output logic                     passes_threshold,
    output logic [OUT_W-1:0]         bin_centre,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);
    logic [15:0] bin_width_reg;
    logic [23:0] min_energy_reg;
    logic [13:0] active_bins_reg;
    logic [9:0]  threshold_reg;

    logic mid_push, mid_full, mid_pop, mid_empty, clearing, res_push, out_full;
    mid_t mid_in, mid_head;
    res_t res_in, res_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg   <= RST_BIN_WIDTH;
            min_energy_reg  <= RST_MIN_ENERGY;
            active_bins_reg <= RST_ACTIVE_BINS;
            threshold_reg   <= RST_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BIN_WIDTH:   bin_width_reg   <= cfg_data[15:0];
                CFG_MIN_ENERGY:  min_energy_reg  <= cfg_data[23:0];
                CFG_ACTIVE_BINS: active_bins_reg <= cfg_data[13:0];
                CFG_THRESHOLD:   threshold_reg   <= cfg_data[9:0];
                default:         ;
            endcase
        end
    end

    ehtq_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .energy      (energy),
        .bin_index   (bin_index),
        .clearing    (clearing),
        .bin_width   (bin_width_reg),
        .active_bins (active_bins_reg),
        .mid_push    (mid_push),
        .mid_data    (mid_in),
        .mid_full    (mid_full)
    );

    ehtq_fifo #(
        .WIDTH ($bits(mid_t)),
        .DEPTH (2)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (mid_in),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_head),
        .empty   (mid_empty)
    );

    ehtq_back #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (mid_head),
        .mid_empty  (mid_empty),
        .mid_pop    (mid_pop),
        .bin_width  (bin_width_reg),
        .min_energy (min_energy_reg),
        .threshold  (threshold_reg),
        .clearing   (clearing),
        .res_push   (res_push),
        .res        (res_in),
        .out_full   (out_full)
    );

    ehtq_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign out_of_range     = res_head.out_of_range;
    assign bin_used         = res_head.bin_used;
    assign detected_count   = res_head.detected_count;
    assign emitted_count    = res_head.emitted_count;
    assign passes_threshold = res_head.passes_threshold;
    assign bin_centre       = res_head.bin_centre;

endmodule
`default_nettype wire
